/* rtl/core/dumb_buffer_handle_table_macros.svh */
// assertion macros shared by the checker
`ifndef DUMB_BUFFER_HANDLE_TABLE_MACROS_SVH
`define DUMB_BUFFER_HANDLE_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DBHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DBHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dbht_pkg.sv */
`default_nettype none

package dbht_pkg;

    // field widths
    localparam int OP_W        = 2;
    localparam int WIDTH_W     = 15;
    localparam int HEIGHT_W    = 15;
    localparam int BPP_W       = 7;
    localparam int HANDLE_W    = 7;
    localparam int OFFSET_W    = 64;
    localparam int STATUS_W    = 2;
    localparam int PITCH_OUT_W = 18;
    localparam int SIZE_W      = 32;

    // internal pitch width: (width * bpp / 8) rounded up to 64 fits in 20 bits
    localparam int PITCH_W     = 20;
    localparam int PROD1_W     = WIDTH_W + BPP_W;
    localparam int PROD2_W     = PITCH_W + HEIGHT_W;

    // stream word widths
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 128;

    // table size and page rounding
    localparam int MAX_HANDLES_DEF = 64;
    localparam int PAGE_BYTES      = 4096;
    localparam logic [SIZE_W-1:0] PAGE_MASK = SIZE_W'(PAGE_BYTES - 1);
    localparam logic [PITCH_W-1:0] PITCH_ROUND = PITCH_W'(63);

    // first map offset handed out after reset
    localparam logic [OFFSET_W-1:0] OFFSET_START = 64'h0000_0001_0000_0000;

    // request codes
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_GET     = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_SLOT    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_HANDLE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND  = 2'd3;

    // one table entry
    typedef struct packed {
        logic                valid;
        logic [SIZE_W-1:0]   size;
        logic [OFFSET_W-1:0] offset;
    } slot_t;

endpackage

`default_nettype wire

/* rtl/core/dumb_buffer_handle_table.sv */
`default_nettype none

// Handle table for scanout buffers with a bump map-offset allocator. Each
// request word takes one of four operations (create, destroy, get offset,
// find by offset) and returns exactly one result word. After reset the block
// first sweeps the slot memory to mark every slot free and takes no request
// during the sweep. Requests are handled one at a time: the slot memory has
// one read and one write port with a registered read. Destroy and get offset
// read the slot of a valid handle and then finish. Find scans the slots one
// per cycle up to the last slot; create first runs the pitch and size
// arithmetic (two registered multiplies) and then scans for the lowest free
// slot. The result sits in an output register, so one finished word may wait
// for the consumer while the next request is already in progress.

module dumb_buffer_handle_table
    import dbht_pkg::*;
#(
    parameter int MAX_HANDLES = MAX_HANDLES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // buf_width, buf_height, bits_per_pixel, handle_in, offset_in, zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // handle_out, pitch_out, size_out, offset_out, zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]         m_axis_tuser
);

    localparam int IDX_W = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_HANDLES - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CALC   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_LOOKUP = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    // control state
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       clr_idx_reg, clr_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0]    next_offset_reg, next_offset_next;

    // request and result payload
    logic [OP_W-1:0]        op_reg, op_next;
    logic [OFFSET_W-1:0]    target_reg, target_next;
    logic [IDX_W-1:0]       lk_idx_reg, lk_idx_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [PITCH_W-1:0]     pitch_reg, pitch_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [HANDLE_W-1:0]    res_handle_reg, res_handle_next;
    logic [PITCH_OUT_W-1:0] res_pitch_reg, res_pitch_next;
    logic [SIZE_W-1:0]      res_size_reg, res_size_next;
    logic [OFFSET_W-1:0]    res_offset_reg, res_offset_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // slot memory
    slot_t                  ram [MAX_HANDLES];
    slot_t                  rd_data_reg;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    slot_t                  ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;

    // request fields
    logic                   in_fire;
    logic [WIDTH_W-1:0]     in_width;
    logic [HEIGHT_W-1:0]    in_height;
    logic [BPP_W-1:0]       in_bpp;
    logic [HANDLE_W-1:0]    in_hin;
    logic [OFFSET_W-1:0]    in_offset;
    logic                   in_bad;
    logic [IDX_W-1:0]       in_idx;
    logic [IDX_W:0]         chk_handle;

    // geometry unit
    logic                   geo_start;
    logic                   geo_done;
    logic [PITCH_W-1:0]     geo_pitch;
    logic [SIZE_W-1:0]      geo_size;

    assign in_width  = s_axis_tdata[14:0];
    assign in_height = s_axis_tdata[29:15];
    assign in_bpp    = s_axis_tdata[36:30];
    assign in_hin    = s_axis_tdata[43:37];
    assign in_offset = s_axis_tdata[107:44];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_bad        = (in_hin == '0) || (int'(in_hin) > MAX_HANDLES);
    assign in_idx        = IDX_W'(in_hin - HANDLE_W'(1));
    assign chk_handle    = {1'b0, chk_idx_reg} + 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // pitch and size arithmetic
    dbht_geom u_geom (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (geo_start),
        .buf_width      (in_width),
        .buf_height     (in_height),
        .bits_per_pixel (in_bpp),
        .done           (geo_done),
        .pitch          (geo_pitch),
        .size           (geo_size)
    );

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram[ram_waddr] <= ram_wdata;
        end
        rd_data_reg <= ram[ram_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        chk_vld_next     = chk_vld_reg;
        next_offset_next = next_offset_reg;
        op_next          = op_reg;
        target_next      = target_reg;
        lk_idx_next      = lk_idx_reg;
        scan_idx_next    = scan_idx_reg;
        chk_idx_next     = chk_idx_reg;
        pitch_next       = pitch_reg;
        size_next        = size_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        res_pitch_next   = res_pitch_reg;
        res_size_next    = res_size_reg;
        res_offset_next  = res_offset_reg;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        ram_we           = 1'b0;
        ram_waddr        = chk_idx_reg;
        ram_wdata        = '0;
        ram_raddr        = scan_idx_reg;
        geo_start        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                ram_raddr = in_idx;
                if (in_fire)
                begin
                    op_next         = s_axis_tuser;
                    target_next     = in_offset;
                    lk_idx_next     = in_idx;
                    scan_idx_next   = '0;
                    chk_vld_next    = 1'b0;
                    res_status_next = STS_OK;
                    res_handle_next = '0;
                    res_pitch_next  = '0;
                    res_size_next   = '0;
                    res_offset_next = '0;
                    case (s_axis_tuser)
                        OP_CREATE:
                        begin
                            geo_start  = 1'b1;
                            state_next = S_CALC;
                        end
                        OP_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (in_bad)
                            begin
                                res_status_next = STS_BAD_HANDLE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_LOOKUP;
                            end
                        end
                    endcase
                end
            end

            S_CALC:
            begin
                if (geo_done)
                begin
                    pitch_next = geo_pitch;
                    size_next  = geo_size;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle, check the word read last cycle
                ram_raddr    = scan_idx_reg;
                chk_vld_next = 1'b1;
                chk_idx_next = scan_idx_reg;
                if (scan_idx_reg != LAST_IDX)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (op_reg == OP_CREATE)
                    begin
                        if (!rd_data_reg.valid)
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = chk_idx_reg;
                            ram_wdata.valid  = 1'b1;
                            ram_wdata.size   = size_reg;
                            ram_wdata.offset = next_offset_reg;
                            res_handle_next  = HANDLE_W'(chk_handle);
                            res_pitch_next   = pitch_reg[PITCH_OUT_W-1:0];
                            res_size_next    = size_reg;
                            res_offset_next  = next_offset_reg;
                            next_offset_next = next_offset_reg + OFFSET_W'(size_reg);
                            state_next       = S_FINISH;
                        end
                        else if (chk_idx_reg == LAST_IDX)
                        begin
                            res_status_next = STS_NO_SLOT;
                            state_next      = S_FINISH;
                        end
                    end
                    else
                    begin
                        if (rd_data_reg.valid && (rd_data_reg.offset == target_reg))
                        begin
                            res_handle_next = HANDLE_W'(chk_handle);
                            res_size_next   = rd_data_reg.size;
                            res_offset_next = rd_data_reg.offset;
                            state_next      = S_FINISH;
                        end
                        else if (chk_idx_reg == LAST_IDX)
                        begin
                            res_status_next = STS_NOT_FOUND;
                            state_next      = S_FINISH;
                        end
                    end
                end
            end

            S_LOOKUP:
            begin
                // slot word for the handle is here now
                if (!rd_data_reg.valid)
                begin
                    res_status_next = STS_BAD_HANDLE;
                end
                else if (op_reg == OP_DESTROY)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = lk_idx_reg;
                    ram_wdata       = rd_data_reg;
                    ram_wdata.valid = 1'b0;
                end
                else
                begin
                    res_offset_next = rd_data_reg.offset;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = {7'b0, res_offset_reg, res_size_reg,
                                       res_pitch_reg, res_handle_reg};
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            chk_vld_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            next_offset_reg <= OFFSET_START;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            chk_vld_reg     <= chk_vld_next;
            out_valid_reg   <= out_valid_next;
            next_offset_reg <= next_offset_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        target_reg     <= target_next;
        lk_idx_reg     <= lk_idx_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        pitch_reg      <= pitch_next;
        size_reg       <= size_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_pitch_reg  <= res_pitch_next;
        res_size_reg   <= res_size_next;
        res_offset_reg <= res_offset_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire

/* rtl/core/dbht_geom.sv */
`default_nettype none

module dbht_geom
    import dbht_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [WIDTH_W-1:0]  buf_width,
    input  wire logic [HEIGHT_W-1:0] buf_height,
    input  wire logic [BPP_W-1:0]    bits_per_pixel,
    output logic                     done,
    output logic [PITCH_W-1:0]       pitch,
    output logic [SIZE_W-1:0]        size
);

    logic [3:0]          vld_reg;
    logic [PROD1_W-1:0]  prod1_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [PROD2_W-1:0]  prod2_reg;
    logic [SIZE_W-1:0]   size_reg;

    logic [PITCH_W-1:0]  pitch_sum;
    logic [SIZE_W-1:0]   size_sum;

    // bytes per row rounded up to 64, size rounded up to a page
    assign pitch_sum = PITCH_W'(prod1_reg[PROD1_W-1:3]) + PITCH_ROUND;
    assign size_sum  = prod2_reg[SIZE_W-1:0] + PAGE_MASK;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    // multiply, round, multiply, round
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod1_reg  <= PROD1_W'(buf_width) * PROD1_W'(bits_per_pixel);
            height_reg <= buf_height;
        end
        if (vld_reg[0])
        begin
            pitch_reg <= {pitch_sum[PITCH_W-1:6], 6'b0};
        end
        if (vld_reg[1])
        begin
            prod2_reg <= PROD2_W'(pitch_reg) * PROD2_W'(height_reg);
        end
        if (vld_reg[2])
        begin
            size_reg <= size_sum & ~PAGE_MASK;
        end
    end

    assign done  = vld_reg[3];
    assign pitch = pitch_reg;
    assign size  = size_reg;

endmodule

`default_nettype wire

/* rtl/core/dbht_checker.sv */
`default_nettype none

`include "dumb_buffer_handle_table_macros.svh"

module dbht_checker
    import dbht_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [STATUS_W-1:0]    m_axis_tuser
);

    logic       in_fire;
    logic       out_fire;
    logic [1:0] pend_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // words taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_fire) - 2'(out_fire);
        end
    end

    `DBHT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
    `DBHT_ASSERT_IMP(a_fail_zero, m_axis_tvalid && (m_axis_tuser != STS_OK), m_axis_tdata == '0, "failed request carries nonzero data")
    `DBHT_ASSERT_IMP(a_no_extra, out_fire, pend_reg != 2'd0, "result word without a request")
    `DBHT_ASSERT_IMP(a_one_inside, in_fire, pend_reg < 2'd2, "request taken with two words outstanding")

endmodule

bind dumb_buffer_handle_table dbht_checker u_dbht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
